// File: design/sbh_pkg.sv
// shared types, constants and round functions for the byte-serial sha-256 hasher
// used by sha256_byte_hasher and its port checker; no dependencies
`default_nettype none

package sbh_pkg;

  localparam logic       OP_APPEND = 1'b0;
  localparam logic       OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [6:0] LOAD_DONE = 7'd64;
  localparam logic [6:0] LIM_FULL  = 7'd64;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [63:0] BYTE_BITS = 64'd8;

  typedef struct packed {
    logic       op;
    logic [7:0] message_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0: w = 32'h6a09e667;
      3'd1: w = 32'hbb67ae85;
      3'd2: w = 32'h3c6ef372;
      3'd3: w = 32'ha54ff53a;
      3'd4: w = 32'h510e527f;
      3'd5: w = 32'h9b05688c;
      3'd6: w = 32'h1f83d9ab;
      3'd7: w = 32'h5be0cd19;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

// File: design/sha256_byte_hasher.sv
// streaming sha-256 hasher: byte buffer memory, schedule window and one round per cycle
// depends on sbh_pkg
`default_nettype none

// Takes one word per accepted input: an append adds a message byte, a finish pads the
// message and returns the eight digest words, index 0 first, then starts a new message.
// An append that does not complete a 64-byte block leaves the input free for the next
// byte. A block streams its bytes out of the byte buffer (one byte per cycle, padding and
// length inserted on the fly), then runs 64 rounds on the one round unit, then folds the
// result into the chaining words; the input stalls meanwhile. A finish processes one
// block, or two when 56 or more bytes are pending, then holds the input until all eight
// digest words are taken, one per cycle at the earliest.
module sha256_byte_hasher (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_stall,
  input  wire sbh_pkg::in_t  in_data,
  output logic           out_valid,
  input  wire            out_stall,
  output sbh_pkg::out_t  out_data
);

  sbh_pkg::state_t state_r, state_nxt;

  logic [6:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [63:0] total_r;
  logic [6:0]  lim_r;
  logic        mark_r;
  logic        len_r;
  logic        pend2_r;
  logic        fin_r;
  logic [2:0]  idx_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];

  logic [7:0]  buf_mem [64];
  logic [7:0]  mem_q_r;
  logic [5:0]  rd_idx_r;

  logic        in_acc;
  logic        out_acc;
  logic        rd_en;
  logic        mem_we;
  logic [7:0]  load_byte;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [31:0] ch;
  logic [31:0] maj;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbh_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.op == sbh_pkg::OP_FINISH || fill_r == sbh_pkg::LAST_BYTE) begin
            state_nxt = sbh_pkg::ST_LOAD;
          end
        end
      end
      sbh_pkg::ST_LOAD: begin
        if (cnt_r == sbh_pkg::LOAD_DONE) begin
          state_nxt = sbh_pkg::ST_ROUND;
        end
      end
      sbh_pkg::ST_ROUND: begin
        if (cnt_r[5:0] == sbh_pkg::LAST_ROUND) begin
          state_nxt = sbh_pkg::ST_UPDATE;
        end
      end
      sbh_pkg::ST_UPDATE: begin
        if (pend2_r) begin
          state_nxt = sbh_pkg::ST_LOAD;
        end else if (fin_r) begin
          state_nxt = sbh_pkg::ST_EMIT;
        end else begin
          state_nxt = sbh_pkg::ST_IDLE;
        end
      end
      sbh_pkg::ST_EMIT: begin
        if (out_acc && idx_r == sbh_pkg::LAST_WORD) begin
          state_nxt = sbh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sbh_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = (state_r != sbh_pkg::ST_IDLE);
    out_valid = (state_r == sbh_pkg::ST_EMIT);
    rd_en     = (state_r == sbh_pkg::ST_LOAD) && !cnt_r[6];
    mem_we    = in_acc && (in_data.op == sbh_pkg::OP_APPEND);
    out_data.digest_word = h_r[idx_r];
    out_data.word_index  = idx_r;
    out_data.last_word   = (idx_r == sbh_pkg::LAST_WORD);
  end

  // byte buffer
  always_ff @(posedge clk) begin
    if (mem_we) begin
      buf_mem[fill_r] <= in_data.message_byte;
    end
    if (rd_en) begin
      mem_q_r  <= buf_mem[cnt_r[5:0]];
      rd_idx_r <= cnt_r[5:0];
    end
  end

  // bytes past the data limit come from the padding rule, length big-endian at the tail
  always_comb begin
    if ({1'b0, rd_idx_r} < lim_r) begin
      load_byte = mem_q_r;
    end else if (mark_r && rd_idx_r == fill_r) begin
      load_byte = sbh_pkg::PAD_MARK;
    end else if (len_r && rd_idx_r >= sbh_pkg::LEN_START) begin
      load_byte = total_r[{~rd_idx_r[2:0], 3'b000} +: 8];
    end else begin
      load_byte = 8'h00;
    end
  end

  // round and schedule
  always_comb begin
    ch    = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    maj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1    = v_r[7] + sbh_pkg::big_sigma1(v_r[4]) + ch
            + sbh_pkg::round_const(cnt_r[5:0]) + w_r[0];
    t2    = sbh_pkg::big_sigma0(v_r[0]) + maj;
    w_new = sbh_pkg::small_sigma1(w_r[14]) + w_r[9]
            + sbh_pkg::small_sigma0(w_r[1]) + w_r[0];
  end

  // schedule window and working variables
  always_ff @(posedge clk) begin
    case (state_r)
      sbh_pkg::ST_LOAD: begin
        for (int i = 0; i < 8; i++) begin
          v_r[i] <= h_r[i];
        end
        if (cnt_r != 7'd0) begin
          for (int k = 0; k < 15; k++) begin
            w_r[k] <= {w_r[k][23:0], w_r[k+1][31:24]};
          end
          w_r[15] <= {w_r[15][23:0], load_byte};
        end
      end
      sbh_pkg::ST_ROUND: begin
        for (int k = 0; k < 15; k++) begin
          w_r[k] <= w_r[k+1];
        end
        w_r[15] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  // control and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbh_pkg::ST_IDLE;
      cnt_r   <= 7'd0;
      fill_r  <= 6'd0;
      total_r <= 64'd0;
      lim_r   <= 7'd0;
      mark_r  <= 1'b0;
      len_r   <= 1'b0;
      pend2_r <= 1'b0;
      fin_r   <= 1'b0;
      idx_r   <= 3'd0;
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= sbh_pkg::init_word(3'(i));
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sbh_pkg::ST_IDLE: begin
          if (in_acc) begin
            cnt_r <= 7'd0;
            if (in_data.op == sbh_pkg::OP_APPEND) begin
              fill_r  <= fill_r + 6'd1;
              total_r <= total_r + sbh_pkg::BYTE_BITS;
              lim_r   <= sbh_pkg::LIM_FULL;
              mark_r  <= 1'b0;
              len_r   <= 1'b0;
              pend2_r <= 1'b0;
              fin_r   <= 1'b0;
            end else begin
              lim_r   <= {1'b0, fill_r};
              mark_r  <= 1'b1;
              len_r   <= (fill_r < sbh_pkg::LEN_START);
              pend2_r <= (fill_r >= sbh_pkg::LEN_START);
              fin_r   <= 1'b1;
            end
          end
        end
        sbh_pkg::ST_LOAD: begin
          cnt_r <= (cnt_r == sbh_pkg::LOAD_DONE) ? 7'd0 : cnt_r + 7'd1;
        end
        sbh_pkg::ST_ROUND: begin
          cnt_r <= cnt_r + 7'd1;
        end
        sbh_pkg::ST_UPDATE: begin
          cnt_r <= 7'd0;
          idx_r <= 3'd0;
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + v_r[i];
          end
          // length-only block after a spilled pad
          if (pend2_r) begin
            lim_r   <= 7'd0;
            mark_r  <= 1'b0;
            len_r   <= 1'b1;
            pend2_r <= 1'b0;
          end
        end
        sbh_pkg::ST_EMIT: begin
          if (out_acc) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == sbh_pkg::LAST_WORD) begin
              fill_r  <= 6'd0;
              total_r <= 64'd0;
              fin_r   <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                h_r[i] <= sbh_pkg::init_word(3'(i));
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/sbh_checker.sv
// port-level checks for sha256_byte_hasher, attached by bind
// depends on sbh_pkg
`default_nettype none

module sbh_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_valid,
  input wire                 in_stall,
  input wire sbh_pkg::in_t   in_data,
  input wire                 out_valid,
  input wire                 out_stall,
  input wire sbh_pkg::out_t  out_data
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input word changed while stalled");

  // stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("digest word changed while stalled");

  // no new input word while a digest is being delivered
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while digest pending");

  // digest words come out in order without gaps
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.word_index != sbh_pkg::LAST_WORD
      |=> out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("digest word index out of sequence");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.last_word == (out_data.word_index == sbh_pkg::LAST_WORD))
    else $error("last word flag wrong");

endmodule

bind sha256_byte_hasher sbh_checker u_sbh_checker (.*);

`default_nettype wire
